// ----- hw/rtl/pktw_pkg.sv -----
// Package of shared types and constants for the per-key time-window sum block.
package pktw_pkg;

   localparam int NUM_UNITS_DEFAULT = 8;
   localparam int LOG_DEPTH_DEFAULT = 32;
   localparam logic [31:0] WINDOW_RESET = 32'd5000;
   localparam logic [30:0] SUM_LIMIT = 31'h7FFF_FFFF;

   localparam logic [1:0] CMD_RECORD = 2'd0;
   localparam logic [1:0] CMD_QUERY  = 2'd1;
   localparam logic [1:0] CMD_FORGET = 2'd2;

   localparam logic CSR_ENABLE = 1'b0;
   localparam logic CSR_WINDOW = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the input transaction
      logic append;     // write the new entry and update the slot pointers
      logic drop_head;  // drop the oldest entry of the slot
      logic forget;     // empty the slot
      logic rd_head;    // read the oldest entry
      logic rd_walk;    // read the entry at the walk offset
      logic acc;        // add the read entry to the sum
      logic clr_sum;    // clear the sum and walk offset
      logic finish;     // place the result into the output register
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_record;
      logic is_query;
      logic is_forget;
      logic rec_ok;
      logic qry_ok;
      logic empty;      // slot holds no live entry
      logic head_old;   // registered oldest entry is outside the window
      logic walk_done;  // walk offset has reached the entry count
   } stat_type;

endpackage

// ----- hw/rtl/per_key_time_window_damage_sum_core.sv -----
// Top level of the per-key time-window sum block.
//
// Each request transaction carries a command (record, query or forget), a unit
// slot, the current millisecond time, an amount, the marker flag and the marker
// age. Exactly one response transaction follows each request, in order.
// A record appends a nonzero amount to the slot's log when enabled and the marker is
// held; an accepted query returns the saturated sum of the amounts still inside the window.
// The block works on one transaction at a time. After the request is taken it is
// decoded; a record or an accepted query then prunes the slot, reading the oldest
// entry and checking its age until it is empty or its oldest entry is in the window,
// and a query then walks the remaining entries, one read and one add per entry, over
// the single-port log memory. A refused command, a forget or the unused command goes
// straight to the result. The result is loaded into the output register once the
// previous response has been taken. The next request can be taken from the cycle
// after the response is loaded.
// The response sits in an output register; while the receiver stalls the
// block finishes the next transaction and waits to deliver it.
// Synchronous reset empties every log and restores enable to 1 and the window
// to 5000 ms. Configuration writes are taken at any time and meant for idle.
module per_key_time_window_damage_sum_core #(
   parameter int NUM_UNITS = pktw_pkg::NUM_UNITS_DEFAULT,
   parameter int LOG_DEPTH = pktw_pkg::LOG_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [2:0]  req_unit_slot,
   input  logic [31:0] req_now_ms,
   input  logic [31:0] req_amount,
   input  logic        req_marker_held,
   input  logic [31:0] req_marker_age_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [30:0] rsp_window_sum,
   output logic        rsp_recorded,
   output logic        rsp_log_overflow,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   pktw_pkg::ctrl_type ct;
   pktw_pkg::stat_type st;

   logic        enable_ff;
   logic [31:0] window_ff;
   logic        rsp_valid_ff;

   // Configuration registers; the port always accepts.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         window_ff <= pktw_pkg::WINDOW_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            pktw_pkg::CSR_ENABLE: enable_ff <= csr_data[0];
            pktw_pkg::CSR_WINDOW: window_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The output register is held until taken; a new result loads on finish.
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (ct.finish) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end
   assign rsp_valid = rsp_valid_ff;

   pktw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .out_busy  (rsp_valid_ff && !rsp_ready),
      .st        (st),
      .ct        (ct)
   );

   pktw_datapath #(
      .NUM_UNITS (NUM_UNITS),
      .LOG_DEPTH (LOG_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ct                (ct),
      .st                (st),
      .cfg_enable        (enable_ff),
      .cfg_window        (window_ff),
      .req_command       (req_command),
      .req_unit_slot     (req_unit_slot),
      .req_now_ms        (req_now_ms),
      .req_amount        (req_amount),
      .req_marker_held   (req_marker_held),
      .req_marker_age_ms (req_marker_age_ms),
      .res_sum           (rsp_window_sum),
      .res_recorded      (rsp_recorded),
      .res_overflow      (rsp_log_overflow)
   );

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ct.finish |-> !(rsp_valid_ff && !rsp_ready)) else $error("response overwritten");
   a_idle_when_valid: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("second request taken");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("response dropped");
`endif

endmodule

// ----- hw/rtl/pktw_ctrl.sv -----
// Controller state machine of the per-key time-window sum block.
module pktw_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               out_busy,
   input  pktw_pkg::stat_type st,
   output pktw_pkg::ctrl_type ct
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_DEC   = 7'b0000010,
      S_HREQ  = 7'b0000100,
      S_HCHK  = 7'b0001000,
      S_WREQ  = 7'b0010000,
      S_WACC  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      summing_ff, summing_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         summing_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         summing_ff <= summing_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      summing_in = summing_ff;
      ct         = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ct.load  = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            ct.clr_sum = 1'b1;
            summing_in = st.qry_ok;
            if (st.is_record && st.rec_ok) begin
               ct.append = 1'b1;
               state_in  = S_HREQ;
            end else if (st.is_query && st.qry_ok) begin
               state_in = S_HREQ;
            end else begin
               ct.forget = st.is_forget;
               state_in  = S_DONE;
            end
         end
         S_HREQ: begin
            if (st.empty) begin
               state_in = summing_ff ? S_WREQ : S_DONE;
            end else begin
               ct.rd_head = 1'b1;
               state_in   = S_HCHK;
            end
         end
         S_HCHK: begin
            if (st.head_old) begin
               ct.drop_head = 1'b1;
               state_in     = S_HREQ;
            end else begin
               state_in = summing_ff ? S_WREQ : S_DONE;
            end
         end
         S_WREQ: begin
            if (st.walk_done) begin
               state_in = S_DONE;
            end else begin
               ct.rd_walk = 1'b1;
               state_in   = S_WACC;
            end
         end
         S_WACC: begin
            ct.acc   = 1'b1;
            state_in = S_WREQ;
         end
         S_DONE: begin
            if (!out_busy) begin
               ct.finish = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

`ifndef ASSERT_OFF
   a_acc_after_read: assert property (@(posedge clock) disable iff (reset)
      ct.rd_walk |=> ct.acc) else $error("accumulate must follow walk read");
   a_check_after_head: assert property (@(posedge clock) disable iff (reset)
      ct.rd_head |=> (state_ff == S_HCHK)) else $error("head read not checked");
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      ct.load |=> !req_ready) else $error("ready while busy");
`endif

endmodule

// ----- hw/rtl/pktw_datapath.sv -----
// Datapath of the per-key time-window sum block: log memory, slot pointers and sum.
module pktw_datapath #(
   parameter int NUM_UNITS = pktw_pkg::NUM_UNITS_DEFAULT,
   parameter int LOG_DEPTH = pktw_pkg::LOG_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  pktw_pkg::ctrl_type ct,
   output pktw_pkg::stat_type st,
   input  logic               cfg_enable,
   input  logic [31:0]        cfg_window,
   input  logic [1:0]         req_command,
   input  logic [2:0]         req_unit_slot,
   input  logic [31:0]        req_now_ms,
   input  logic [31:0]        req_amount,
   input  logic               req_marker_held,
   input  logic [31:0]        req_marker_age_ms,
   output logic [30:0]        res_sum,
   output logic               res_recorded,
   output logic               res_overflow
);

   localparam int SW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
   localparam int PW = $clog2(LOG_DEPTH);
   localparam int CW = $clog2(LOG_DEPTH + 1);
   localparam int AW = $clog2(NUM_UNITS * LOG_DEPTH);

   logic [31:0] mem_time [NUM_UNITS*LOG_DEPTH];
   logic [31:0] mem_amt  [NUM_UNITS*LOG_DEPTH];

   logic [PW-1:0] oldest_ff [NUM_UNITS];
   logic [CW-1:0] count_ff  [NUM_UNITS];

   logic [1:0]    cmd_ff;
   logic [SW-1:0] slot_ff;
   logic          slot_ok_ff;
   logic [31:0]   now_ff, amt_ff, age_ff;
   logic          mark_ff, ovf_ff, rec_ff;
   logic [31:0]   rd_time_ff, rd_amt_ff;
   logic [CW-1:0] walk_ff;
   logic [31:0]   sum_ff;

   logic [PW-1:0] cur_old;
   logic [CW-1:0] cur_cnt;
   logic          full;
   logic [PW-1:0] base_old;
   logic [CW-1:0] base_cnt;
   logic [PW-1:0] wr_off, walk_off, old_inc;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0]   age;
   logic [32:0]   sum_wide;

   assign cur_old = oldest_ff[slot_ff];
   assign cur_cnt = count_ff[slot_ff];
   assign full    = (cur_cnt == CW'(LOG_DEPTH));

   function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] a, logic [CW-1:0] b);
      logic [CW:0] s;
      s = CW'(a) + b;
      if (s >= (CW+1)'(LOG_DEPTH)) s = s - (CW+1)'(LOG_DEPTH);
      return s[PW-1:0];
   endfunction

   assign old_inc  = wrap_add(cur_old, CW'(1));
   assign base_old = full ? old_inc : cur_old;
   assign base_cnt = full ? cur_cnt - CW'(1) : cur_cnt;
   assign wr_off   = wrap_add(base_old, base_cnt);
   assign walk_off = wrap_add(cur_old, walk_ff);
   assign wr_addr  = AW'(slot_ff) * AW'(LOG_DEPTH) + AW'(wr_off);
   assign rd_addr  = AW'(slot_ff) * AW'(LOG_DEPTH) + AW'(ct.rd_head ? cur_old : walk_off);

   assign age      = now_ff - rd_time_ff;
   assign sum_wide = {1'b0, sum_ff} + {1'b0, rd_amt_ff};

   always_comb begin
      st.is_record = slot_ok_ff && (cmd_ff == pktw_pkg::CMD_RECORD);
      st.is_query  = slot_ok_ff && (cmd_ff == pktw_pkg::CMD_QUERY);
      st.is_forget = slot_ok_ff && (cmd_ff == pktw_pkg::CMD_FORGET);
      st.rec_ok    = cfg_enable && (amt_ff != 32'd0) && mark_ff;
      st.qry_ok    = st.is_query && cfg_enable && mark_ff && (age_ff >= cfg_window);
      st.empty     = (cur_cnt == '0);
      st.head_old  = (age > cfg_window);
      st.walk_done = (walk_ff == cur_cnt);
   end

   always_ff @(posedge clock) begin
      if (ct.append) begin
         mem_time[wr_addr] <= now_ff;
         mem_amt[wr_addr]  <= amt_ff;
      end
      if (ct.rd_head || ct.rd_walk) begin
         rd_time_ff <= mem_time[rd_addr];
         rd_amt_ff  <= mem_amt[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_UNITS; i++) begin
            oldest_ff[i] <= '0;
            count_ff[i]  <= '0;
         end
      end else if (ct.append) begin
         oldest_ff[slot_ff] <= base_old;
         count_ff[slot_ff]  <= base_cnt + CW'(1);
      end else if (ct.drop_head) begin
         oldest_ff[slot_ff] <= old_inc;
         count_ff[slot_ff]  <= cur_cnt - CW'(1);
      end else if (ct.forget) begin
         oldest_ff[slot_ff] <= '0;
         count_ff[slot_ff]  <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ct.load) begin
         cmd_ff     <= req_command;
         slot_ff    <= SW'(req_unit_slot);
         slot_ok_ff <= ({29'd0, req_unit_slot} < 32'(NUM_UNITS));
         now_ff     <= req_now_ms;
         amt_ff     <= req_amount;
         age_ff     <= req_marker_age_ms;
         mark_ff    <= req_marker_held;
      end
      if (ct.clr_sum) begin
         sum_ff <= '0;
         walk_ff <= '0;
         rec_ff <= ct.append;
         ovf_ff <= ct.append && full;
      end
      if (ct.acc) begin
         sum_ff  <= sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
         walk_ff <= walk_ff + CW'(1);
      end
      if (ct.finish) begin
         res_sum      <= (sum_ff > {1'b0, pktw_pkg::SUM_LIMIT}) ? pktw_pkg::SUM_LIMIT
                                                                : sum_ff[30:0];
         res_recorded <= rec_ff;
         res_overflow <= ovf_ff;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (ct.append || ct.drop_head) |-> cur_cnt <= CW'(LOG_DEPTH))
      else $error("entry count beyond depth");
   a_drop_nonempty: assert property (@(posedge clock) disable iff (reset)
      ct.drop_head |-> !st.empty) else $error("drop from empty log");
   a_ovf_implies_rec: assert property (@(posedge clock) disable iff (reset)
      ct.finish && ovf_ff |-> rec_ff) else $error("overflow without record");
`endif

endmodule

// ----- verif/per_key_time_window_damage_sum_core_test.sv -----
// Self-checking testbench for the per-key time-window damage sum core.
`timescale 1ns / 1ps

module per_key_time_window_damage_sum_core_test;

   localparam int UNITS = pktw_pkg::NUM_UNITS_DEFAULT;
   localparam int DEPTH = pktw_pkg::LOG_DEPTH_DEFAULT;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // One request transaction as it is handed to the driver.
   typedef struct {
      logic [1:0]  command;
      logic [2:0]  slot;
      logic [31:0] now_ms;
      logic [31:0] amount;
      logic        marker;
      logic [31:0] marker_age;
   } damage_req_type;

   // One response transaction as the block should deliver it.
   typedef struct {
      logic [30:0] sum;
      logic        recorded;
      logic        overflow;
   } damage_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_command;
   logic [2:0]  req_unit_slot;
   logic [31:0] req_now_ms;
   logic [31:0] req_amount;
   logic        req_marker_held;
   logic [31:0] req_marker_age_ms;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [30:0] rsp_window_sum;
   logic        rsp_recorded;
   logic        rsp_log_overflow;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [31:0] csr_data;

   per_key_time_window_damage_sum_core dut (.*);

   // Clock with a 12 ns period.
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The predictor's private copy of the configuration and the slot logs.
   logic        pred_enable;
   logic [31:0] pred_window;
   logic [31:0] log_time   [UNITS][DEPTH];
   logic [31:0] log_amount [UNITS][DEPTH];
   int          log_head   [UNITS];
   int          log_count  [UNITS];

   damage_req_type pending_reqs[$];
   damage_rsp_type expected_rsps[$];
   int             error_count = 0;

   // Drops entries from the oldest end while their wrapped age exceeds the
   // window.
   function automatic void prune_slot(int s, logic [31:0] now);
      logic [31:0] age;
      while (log_count[s] > 0) begin
         age = now - log_time[s][log_head[s]];
         if (age <= pred_window) break;
         log_head[s] = (log_head[s] + 1) % DEPTH;
         log_count[s]--;
      end
   endfunction

   // Works out the response to one accepted request and updates the logs.
   function automatic damage_rsp_type predict_damage(damage_req_type r);
      damage_rsp_type res;
      logic [63:0]    total;
      int             s;
      int             pos;
      res   = '{sum: '0, recorded: 1'b0, overflow: 1'b0};
      total = '0;
      s     = r.slot;
      if (s < UNITS) begin
         case (r.command)
            pktw_pkg::CMD_RECORD: begin
               if (pred_enable && r.amount != 0 && r.marker) begin
                  if (log_count[s] >= DEPTH) begin
                     log_head[s] = (log_head[s] + 1) % DEPTH;
                     log_count[s]--;
                     res.overflow = 1'b1;
                  end
                  pos = (log_head[s] + log_count[s]) % DEPTH;
                  log_time[s][pos]   = r.now_ms;
                  log_amount[s][pos] = r.amount;
                  log_count[s]++;
                  res.recorded = 1'b1;
                  prune_slot(s, r.now_ms);
               end
            end
            pktw_pkg::CMD_QUERY: begin
               if (pred_enable && r.marker && r.marker_age >= pred_window) begin
                  prune_slot(s, r.now_ms);
                  for (int i = 0; i < log_count[s]; i++)
                     total += log_amount[s][(log_head[s] + i) % DEPTH];
                  res.sum = (total > 64'(pktw_pkg::SUM_LIMIT)) ? pktw_pkg::SUM_LIMIT
                                                                : total[30:0];
               end
            end
            pktw_pkg::CMD_FORGET: begin
               log_count[s] = 0;
               log_head[s]  = 0;
            end
            default: ;
         endcase
      end
      return res;
   endfunction

   // Gaps are often zero so that back-to-back stretches occur as well.
   function automatic int idle_draw();
      return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
   endfunction

   // Set when the transaction on the request channel went through at the last
   // rising edge.
   bit req_ready_seen = 1'b0;

   // Driver: presents queued requests at the falling edge after a random gap.
   // Valid stays high with a steady payload until the block takes it.
   int req_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready_seen) begin
         // Still waiting for the current transaction to be accepted.
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap   <= req_gap - 1;
      end else if (pending_reqs.size() > 0) begin
         damage_req_type r;
         r = pending_reqs[0];
         pending_reqs.delete(0);
         req_valid         <= 1'b1;
         req_command       <= r.command;
         req_unit_slot     <= r.slot;
         req_now_ms        <= r.now_ms;
         req_amount        <= r.amount;
         req_marker_held   <= r.marker;
         req_marker_age_ms <= r.marker_age;
         req_gap           <= idle_draw();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Notes each accepted request and predicts its response at that moment.
   always @(posedge clock) begin
      req_ready_seen <= (!reset && req_valid && req_ready);
      if (!reset && req_valid && req_ready) begin
         expected_rsps.insert(expected_rsps.size(), predict_damage('{req_command,
            req_unit_slot, req_now_ms, req_amount, req_marker_held, req_marker_age_ms}));
      end
   end

   // Receiver stall: ready toggles with random hold times at the falling edge.
   int rsp_hold = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_ready <= ~rsp_ready | ($urandom_range(0, 1) == 1);
         rsp_hold  <= idle_draw();
      end
   end

   // Monitor: compares every accepted response with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response sum=%0d rec=%0b ovf=%0b", $realtime,
               rsp_window_sum, rsp_recorded, rsp_log_overflow);
            error_count++;
         end else begin
            damage_rsp_type want;
            want = expected_rsps[0];
            expected_rsps.delete(0);
            if (rsp_window_sum !== want.sum) begin
               $display("%0t: window_sum expected %0d actual %0d", $realtime,
                  want.sum, rsp_window_sum);
               error_count++;
            end
            if (rsp_recorded !== want.recorded) begin
               $display("%0t: recorded expected %0b actual %0b", $realtime,
                  want.recorded, rsp_recorded);
               error_count++;
            end
            if (rsp_log_overflow !== want.overflow) begin
               $display("%0t: log_overflow expected %0b actual %0b", $realtime,
                  want.overflow, rsp_log_overflow);
               error_count++;
            end
         end
      end
   end

   // Register write through the configuration channel; the predictor takes
   // the new value at the same moment.
   task automatic write_csr(logic index, logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == pktw_pkg::CSR_ENABLE) pred_enable = value[0];
      else pred_window = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Lets every queued request pass and every response arrive, then waits out
   // the longest walk so the block is idle before the next register write.
   task automatic drain_block();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (4 * DEPTH + 20) @(posedge clock);
   endtask

   function automatic void queue_req(logic [1:0] c, logic [2:0] s, logic [31:0] t,
                                     logic [31:0] a, logic m, logic [31:0] g);
      damage_req_type r;
      r = '{c, s, t, a, m, g};
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   // A burst that mostly records into and queries a few slots with time
   // advancing in small steps, so that logs fill, overflow and age out; some
   // items are wide random noise.
   task automatic random_phase(int n, logic [31:0] step_max);
      logic [31:0] clock_ms;
      logic [2:0]  s;
      int          kind;
      clock_ms = $urandom;
      for (int i = 0; i < n; i++) begin
         clock_ms += $urandom_range(0, step_max);
         s    = 3'($urandom_range(0, 3));
         kind = $urandom_range(0, 99);
         if (kind < 55)
            queue_req(pktw_pkg::CMD_RECORD, s, clock_ms,
               ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 5000),
               $urandom_range(0, 9) != 0, $urandom);
         else if (kind < 85)
            queue_req(pktw_pkg::CMD_QUERY, s, clock_ms, $urandom,
               $urandom_range(0, 9) != 0,
               ($urandom_range(0, 3) == 0) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 9));
         else if (kind < 90)
            queue_req(pktw_pkg::CMD_FORGET, s, clock_ms, $urandom, 1'($urandom), $urandom);
         else
            queue_req(2'($urandom), 3'($urandom), $urandom, $urandom, 1'($urandom),
               $urandom);
      end
      drain_block();
   endtask

   initial begin
      req_valid         = 1'b0;
      req_command       = pktw_pkg::CMD_RECORD;
      req_unit_slot     = '0;
      req_now_ms        = '0;
      req_amount        = '0;
      req_marker_held   = 1'b0;
      req_marker_age_ms = '0;
      rsp_ready         = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = pktw_pkg::CSR_ENABLE;
      csr_data          = '0;
      pred_enable       = 1'b1;
      pred_window       = pktw_pkg::WINDOW_RESET;
      for (int u = 0; u < UNITS; u++) begin
         log_head[u]  = 0;
         log_count[u] = 0;
      end
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: refused records, saturation, wraparound ages, overflow,
      // refused queries, forget, the unused command.
      queue_req(pktw_pkg::CMD_RECORD, 3'd0, 32'd100, 32'd0, 1'b1, 32'd0);
      queue_req(pktw_pkg::CMD_RECORD, 3'd0, 32'd100, 32'd5, 1'b0, 32'd0);
      queue_req(pktw_pkg::CMD_RECORD, 3'd0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b1, 32'd0);
      queue_req(pktw_pkg::CMD_RECORD, 3'd0, 32'd20, 32'hFFFF_FFFF, 1'b1, 32'd0);
      queue_req(pktw_pkg::CMD_QUERY, 3'd0, 32'd30, 32'd0, 1'b1, 32'hFFFF_FFFF);
      queue_req(pktw_pkg::CMD_QUERY, 3'd0, 32'd30, 32'd0, 1'b1, 32'd4999);
      queue_req(pktw_pkg::CMD_QUERY, 3'd0, 32'd30, 32'd0, 1'b0, 32'd5000);
      queue_req(pktw_pkg::CMD_QUERY, 3'd0, 32'd5010, 32'd0, 1'b1, 32'd5000);
      queue_req(pktw_pkg::CMD_QUERY, 3'd0, 32'd5020, 32'd0, 1'b1, 32'd5000);
      for (int i = 0; i < DEPTH + 2; i++)
         queue_req(pktw_pkg::CMD_RECORD, 3'd7, 32'd1000 + 32'(i), 32'(i + 1), 1'b1, 32'd0);
      queue_req(pktw_pkg::CMD_QUERY, 3'd7, 32'd1100, 32'd0, 1'b1, 32'd6000);
      queue_req(pktw_pkg::CMD_FORGET, 3'd7, 32'd0, 32'd0, 1'b0, 32'd0);
      queue_req(pktw_pkg::CMD_QUERY, 3'd7, 32'd1100, 32'd0, 1'b1, 32'd6000);
      queue_req(CMD_UNUSED, 3'd1, 32'd5, 32'd5, 1'b1, 32'd5);
      drain_block();

      // Disabled: records ignored and queries zero.
      write_csr(pktw_pkg::CSR_ENABLE, 32'd0);
      queue_req(pktw_pkg::CMD_RECORD, 3'd2, 32'd10, 32'd9, 1'b1, 32'd0);
      queue_req(pktw_pkg::CMD_QUERY, 3'd0, 32'd10, 32'd0, 1'b1, 32'hFFFF_FFFF);
      drain_block();
      write_csr(pktw_pkg::CSR_ENABLE, 32'd1);

      write_csr(pktw_pkg::CSR_WINDOW, 32'd0);
      random_phase(150, 2);
      write_csr(pktw_pkg::CSR_WINDOW, 32'hFFFF_FFFF);
      random_phase(200, 32'h4000_0000);
      write_csr(pktw_pkg::CSR_WINDOW, 32'd200);
      random_phase(300, 20);
      write_csr(pktw_pkg::CSR_ENABLE, 32'd0);
      random_phase(50, 20);
      write_csr(pktw_pkg::CSR_ENABLE, 32'd1);
      write_csr(pktw_pkg::CSR_WINDOW, pktw_pkg::WINDOW_RESET);
      random_phase(300, 400);

      // Let any last response out and ensure nothing else appears.
      repeat (4 * DEPTH + 20) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #50ms;
      $display("FAILURE");
      $finish;
   end

endmodule
